### hw/rtl/pl0_pkg.sv
// pl0_pkg: shared constants, opcode codes and controller/datapath interface types
// for the p-machine step unit; no dependencies
package pl0_pkg;

  localparam int STACK_DEPTH_DEF = 256;
  localparam int CODE_DEPTH_DEF  = 512;
  localparam int MAX_LEVELS_DEF  = 3;
  localparam int WORD_BITS_DEF   = 32;

  localparam int OP_BITS    = 4;
  localparam int LEV_BITS   = 2;
  localparam int M_BITS     = 32;
  localparam int FAULT_BITS = 2;

  // instruction codes
  localparam logic [3:0] OP_LIT = 4'd1;
  localparam logic [3:0] OP_OPR = 4'd2;
  localparam logic [3:0] OP_LOD = 4'd3;
  localparam logic [3:0] OP_STO = 4'd4;
  localparam logic [3:0] OP_CAL = 4'd5;
  localparam logic [3:0] OP_INC = 4'd6;
  localparam logic [3:0] OP_JMP = 4'd7;
  localparam logic [3:0] OP_JPC = 4'd8;
  localparam logic [3:0] OP_PRT = 4'd9;
  localparam logic [3:0] OP_RED = 4'd10;
  localparam logic [3:0] OP_HLT = 4'd11;

  // operation numbers for OPR
  localparam logic [3:0] OPR_RET = 4'd0;
  localparam logic [3:0] OPR_NEG = 4'd1;
  localparam logic [3:0] OPR_ADD = 4'd2;
  localparam logic [3:0] OPR_SUB = 4'd3;
  localparam logic [3:0] OPR_MUL = 4'd4;
  localparam logic [3:0] OPR_DIV = 4'd5;
  localparam logic [3:0] OPR_ODD = 4'd6;
  localparam logic [3:0] OPR_MOD = 4'd7;
  localparam logic [3:0] OPR_EQL = 4'd8;
  localparam logic [3:0] OPR_NEQ = 4'd9;
  localparam logic [3:0] OPR_LSS = 4'd10;
  localparam logic [3:0] OPR_LEQ = 4'd11;
  localparam logic [3:0] OPR_GTR = 4'd12;
  localparam logic [3:0] OPR_GEQ = 4'd13;

  // fault codes
  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_DIV0  = 2'd1;
  localparam logic [1:0] FLT_RANGE = 2'd2;
  localparam logic [1:0] FLT_BADOP = 2'd3;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE   = 4'd0,
    CMD_CLEAR  = 4'd1,  // write zero at clear address, advance
    CMD_LOAD   = 4'd2,  // capture item, start decode
    CMD_RDA    = 4'd3,  // capture operand b from read data
    CMD_LINK   = 4'd4,  // take static link from read data
    CMD_OPS    = 4'd5,  // capture operand read data
    CMD_DIVGO  = 4'd6,  // start divider
    CMD_EXEC   = 4'd7,  // evaluate and commit
    CMD_WR     = 4'd8,  // extra write (call frame)
    CMD_TOPRD  = 4'd9,  // read top of stack
    CMD_DONE   = 4'd10  // present result
  } cmd_e_t;

  typedef struct packed {
    cmd_e_t     cmd;
    logic [1:0] sel;   // read slot select
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic links_left;
    logic div_busy;
    logic need_div;
    logic frame_wr;   // call writes pending
    logic halted;
  } dp_stat_t;

endpackage

### hw/rtl/pl0_divider.sv
// pl0_divider: radix-2 restoring divider for signed truncating div and mod
// no dependencies
module pl0_divider #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [WORD_BITS-1:0] dividend,
  input  logic [WORD_BITS-1:0] divisor,
  output logic                 busy,
  output logic [WORD_BITS-1:0] quotient,
  output logic [WORD_BITS-1:0] remainder
);
  localparam int CNT_BITS = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] quo;
  logic [WORD_BITS-1:0] rem;
  logic [WORD_BITS-1:0] den;
  logic [CNT_BITS-1:0]  count;
  logic                 neg_q;
  logic                 neg_r;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS-1:0] mag_a;
  logic [WORD_BITS-1:0] mag_b;

  assign mag_a = dividend[WORD_BITS-1] ? -dividend : dividend;
  assign mag_b = divisor[WORD_BITS-1] ? -divisor : divisor;
  assign trial = {rem, quo[WORD_BITS-1]} - {1'b0, den};

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (go) begin
      count <= CNT_BITS'(WORD_BITS);
      quo   <= mag_a;
      rem   <= '0;
      den   <= mag_b;
      neg_q <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
      neg_r <= dividend[WORD_BITS-1];
    end else if (count != '0) begin
      count <= count - 1'b1;
      if (!trial[WORD_BITS]) begin
        rem <= trial[WORD_BITS-1:0];
        quo <= {quo[WORD_BITS-2:0], 1'b1};
      end else begin
        rem <= {rem[WORD_BITS-2:0], quo[WORD_BITS-1]};
        quo <= {quo[WORD_BITS-2:0], 1'b0};
      end
    end
  end

  assign busy      = (count != '0);
  assign quotient  = neg_q ? -quo : quo;
  assign remainder = neg_r ? -rem : rem;
endmodule

### hw/rtl/pl0_datapath.sv
// pl0_datapath: stack memory, pointers, address walk, alu and result registers
// depends on pl0_pkg and pl0_divider
module pl0_datapath #(
  parameter int STACK_DEPTH = pl0_pkg::STACK_DEPTH_DEF,
  parameter int CODE_DEPTH  = pl0_pkg::CODE_DEPTH_DEF,
  parameter int MAX_LEVELS  = pl0_pkg::MAX_LEVELS_DEF,
  parameter int WORD_BITS   = pl0_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pl0_pkg::dp_cmd_t            ctl,
  output pl0_pkg::dp_stat_t           stat,
  input  logic [pl0_pkg::OP_BITS-1:0] opcode,
  input  logic [pl0_pkg::LEV_BITS-1:0] lex_level,
  input  logic signed [pl0_pkg::M_BITS-1:0] operand_m,
  input  logic signed [pl0_pkg::M_BITS-1:0] read_value,
  output logic [8:0]                  next_pc,
  output logic [7:0]                  frame_base,
  output logic [7:0]                  stack_top_index,
  output logic signed [31:0]          top_value,
  output logic                        print_valid,
  output logic signed [31:0]          print_value,
  output logic                        halted,
  output logic [1:0]                  fault_code
);
  import pl0_pkg::*;

  localparam int SA = $clog2(STACK_DEPTH);
  localparam int PA = $clog2(CODE_DEPTH);
  localparam int XW = (M_BITS > WORD_BITS ? M_BITS : WORD_BITS) + 2;

  // stack memory
  logic [WORD_BITS-1:0] mem [STACK_DEPTH];
  logic [SA-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [SA-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // architectural state
  logic [SA-1:0] sp, bp;
  logic [PA-1:0] pc;
  logic          hlt;
  logic [SA:0]   clr;

  // item and scratch registers
  logic [3:0]           op;
  logic [1:0]           lev;
  logic signed [M_BITS-1:0] m;
  logic [WORD_BITS-1:0] rdv;
  logic [1:0]           links;
  logic                 lnk_bad;
  logic [SA-1:0]        lnk;
  logic [WORD_BITS-1:0] opa, opb;
  logic [1:0]           wslot;
  logic                 div_go;
  logic                 div_busy;
  logic [WORD_BITS-1:0] quo, remd;

  pl0_divider #(.WORD_BITS(WORD_BITS)) u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(opa), .divisor(opb),
    .busy(div_busy), .quotient(quo), .remainder(remd)
  );

  // word as address check
  function automatic logic word_ok(input logic [WORD_BITS-1:0] w, input int lim);
    logic ok;
    ok = !w[WORD_BITS-1] && ({{(XW-WORD_BITS){1'b0}}, w} < XW'(lim));
    return ok;
  endfunction

  logic [3:0] mop;
  assign mop = m[3:0];
  logic m_small;
  assign m_small = (m >= 0) && (m <= 13);
  logic lev_bad;
  assign lev_bad = (MAX_LEVELS < 3) && (32'(lev) > MAX_LEVELS)
                   && (op == OP_LOD || op == OP_STO || op == OP_CAL);

  // effective address for load / store
  logic signed [XW-1:0] ea;
  assign ea = XW'(signed'({1'b0, lnk})) + XW'(m);
  logic ea_ok;
  assign ea_ok = !lnk_bad && (ea >= 0) && (ea < XW'(STACK_DEPTH));

  // new stack pointer for INC
  logic signed [XW-1:0] inc_t;
  assign inc_t = XW'(signed'({1'b0, sp})) + XW'(m);

  logic [PA:0] nxt;
  assign nxt = (32'(pc) + 1 == CODE_DEPTH) ? '0 : (PA+1)'(pc) + 1'b1;

  logic m_pc_ok;
  assign m_pc_ok = (m >= 0) && (m < XW'(CODE_DEPTH));

  // read address plan: slot b is the top word (return pc word for RET),
  // slot a the second operand (load address, saved base for RET)
  logic is_ret;
  assign is_ret = (op == OP_OPR) && m_small && (mop == OPR_RET);
  logic [SA-1:0] addr_a;
  always_comb begin
    addr_a = sp;
    case (ctl.sel)
      2'd0: addr_a = is_ret ? bp + SA'(3) : sp;
      2'd1: begin
        if (is_ret) addr_a = bp + SA'(2);
        else if (op == OP_LOD) addr_a = ea[SA-1:0];
        else addr_a = sp - 1'b1;
      end
      2'd2: addr_a = lnk + 1'b1;
      default: addr_a = sp;
    endcase
  end

  // compare helpers
  logic signed [WORD_BITS-1:0] sa, sb;
  assign sa = opa;
  assign sb = opb;

  // outcome of the item
  logic [1:0]           f;
  logic                 n_wr;
  logic [SA-1:0]        n_waddr;
  logic [WORD_BITS-1:0] n_wdata;
  logic [SA-1:0]        n_sp, n_bp;
  logic [PA-1:0]        n_pc;
  logic                 n_pv;
  logic                 n_hlt;
  logic                 n_frame;
  logic [WORD_BITS-1:0] prod;
  assign prod = opa * opb;

  always_comb begin
    f = FLT_NONE; n_wr = 1'b0; n_waddr = sp; n_wdata = '0;
    n_sp = sp; n_bp = bp; n_pc = pc; n_pv = 1'b0; n_hlt = hlt; n_frame = 1'b0;
    if (lev_bad) begin
      f = FLT_BADOP;
    end else begin
      case (op)
        OP_LIT, OP_RED: begin
          if (32'(sp) + 1 >= STACK_DEPTH) f = FLT_RANGE;
          else begin
            n_sp = sp + 1'b1; n_wr = 1'b1; n_waddr = sp + 1'b1;
            n_wdata = (op == OP_LIT) ? WORD_BITS'(m) : rdv;
            n_pc = nxt[PA-1:0];
          end
        end
        OP_OPR: begin
          if (!m_small) f = FLT_BADOP;
          else if (mop == OPR_RET) begin
            if (bp == '0 || 32'(bp) + 3 >= STACK_DEPTH) f = FLT_RANGE;
            else if (!word_ok(opb, CODE_DEPTH)) f = FLT_BADOP;
            else if (!word_ok(opa, STACK_DEPTH)) f = FLT_RANGE;
            else begin
              n_sp = bp - 1'b1; n_pc = opb[PA-1:0]; n_bp = opa[SA-1:0];
            end
          end else if (mop == OPR_NEG || mop == OPR_ODD) begin
            n_wr = 1'b1; n_waddr = sp;
            n_wdata = (mop == OPR_NEG) ? -opb : {{(WORD_BITS-1){1'b0}}, opb[0]};
            n_pc = nxt[PA-1:0];
          end else if (sp == '0) f = FLT_RANGE;
          else if ((mop == OPR_DIV || mop == OPR_MOD) && opb == '0) f = FLT_DIV0;
          else begin
            n_wr = 1'b1; n_waddr = sp - 1'b1; n_sp = sp - 1'b1; n_pc = nxt[PA-1:0];
            case (mop)
              OPR_ADD: n_wdata = opa + opb;
              OPR_SUB: n_wdata = opa - opb;
              OPR_MUL: n_wdata = prod;
              OPR_DIV: n_wdata = quo;
              OPR_MOD: n_wdata = remd;
              OPR_EQL: n_wdata = WORD_BITS'(opa == opb);
              OPR_NEQ: n_wdata = WORD_BITS'(opa != opb);
              OPR_LSS: n_wdata = WORD_BITS'(sa < sb);
              OPR_LEQ: n_wdata = WORD_BITS'(sa <= sb);
              OPR_GTR: n_wdata = WORD_BITS'(sa > sb);
              default: n_wdata = WORD_BITS'(sa >= sb);
            endcase
          end
        end
        OP_LOD: begin
          if (!ea_ok || 32'(sp) + 1 >= STACK_DEPTH) f = FLT_RANGE;
          else begin
            n_wr = 1'b1; n_waddr = sp + 1'b1; n_wdata = opa;
            n_sp = sp + 1'b1; n_pc = nxt[PA-1:0];
          end
        end
        OP_STO: begin
          if (!ea_ok || sp == '0) f = FLT_RANGE;
          else begin
            n_wr = 1'b1; n_waddr = ea[SA-1:0]; n_wdata = opb;
            n_sp = sp - 1'b1; n_pc = nxt[PA-1:0];
          end
        end
        OP_CAL: begin
          if (lnk_bad || 32'(sp) + 4 >= STACK_DEPTH) f = FLT_RANGE;
          else if (!m_pc_ok) f = FLT_BADOP;
          else begin
            n_frame = 1'b1; n_bp = sp + 1'b1; n_pc = m[PA-1:0];
          end
        end
        OP_INC: begin
          if ((inc_t < 0) || (inc_t >= XW'(STACK_DEPTH)))
            f = FLT_RANGE;
          else begin
            n_sp = SA'(inc_t); n_pc = nxt[PA-1:0];
          end
        end
        OP_JMP: begin
          if (!m_pc_ok) f = FLT_BADOP;
          else n_pc = m[PA-1:0];
        end
        OP_JPC: begin
          if (!m_pc_ok) f = FLT_BADOP;
          else if (sp == '0) f = FLT_RANGE;
          else begin
            n_pc = (opb == '0) ? m[PA-1:0] : nxt[PA-1:0];
            n_sp = sp - 1'b1;
          end
        end
        OP_PRT: begin
          if (sp == '0) f = FLT_RANGE;
          else begin
            n_pv = 1'b1; n_sp = sp - 1'b1; n_pc = nxt[PA-1:0];
          end
        end
        OP_HLT: n_hlt = 1'b1;
        default: f = FLT_BADOP;
      endcase
    end
    if (f != FLT_NONE) begin
      n_wr = 1'b0; n_frame = 1'b0; n_sp = sp; n_bp = bp; n_pc = pc; n_pv = 1'b0;
    end
  end

  // frame word for call writes
  logic [SA-1:0] fbase;
  logic [SA-1:0] frame_bp;
  logic [PA-1:0] frame_ret;
  logic [SA-1:0] frame_lnk;
  logic [WORD_BITS-1:0] frame_word;
  always_comb begin
    case (wslot)
      2'd0: frame_word = '0;
      2'd1: frame_word = WORD_BITS'(frame_lnk);
      2'd2: frame_word = WORD_BITS'(frame_bp);
      default: frame_word = WORD_BITS'(frame_ret);
    endcase
  end

  // memory port steering: clear, call frame or the alu result in the cycle after exec
  logic [SA-1:0] ex_waddr;
  logic [WORD_BITS-1:0] ex_wdata;
  logic ex_wr;
  always_comb begin
    wr_en = 1'b0; wr_addr = fbase + SA'(wslot); wr_data = frame_word; rd_addr = addr_a;
    if (ex_wr) begin
      wr_en = 1'b1; wr_addr = ex_waddr; wr_data = ex_wdata;
    end
    case (ctl.cmd)
      CMD_CLEAR: begin wr_en = 1'b1; wr_addr = clr[SA-1:0]; wr_data = '0; end
      CMD_WR:    wr_en = 1'b1;
      CMD_TOPRD: rd_addr = sp;
      default: ;
    endcase
  end

  // sequential state
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0; bp <= SA'(1); pc <= '0; hlt <= 1'b0; clr <= '0; links <= '0;
      print_valid <= 1'b0; fault_code <= FLT_NONE; wslot <= '0; div_go <= 1'b0;
    end else begin
      div_go <= 1'b0;
      case (ctl.cmd)
        CMD_CLEAR: clr <= clr + 1'b1;
        CMD_LOAD: begin
          op <= opcode; lev <= lex_level; m <= operand_m;
          rdv <= WORD_BITS'(read_value);
          links <= lex_level; lnk <= bp; lnk_bad <= 1'b0;
          print_valid <= 1'b0; fault_code <= FLT_NONE;
        end
        CMD_LINK: begin
          links <= links - 1'b1;
          if (lnk_bad || 32'(lnk) + 1 >= STACK_DEPTH || !word_ok(rd_data, STACK_DEPTH))
            lnk_bad <= 1'b1;
          else lnk <= rd_data[SA-1:0];
        end
        CMD_RDA: opb <= rd_data;
        CMD_OPS: opa <= rd_data;
        CMD_DIVGO: div_go <= 1'b1;
        CMD_EXEC: begin
          sp <= n_sp; bp <= n_bp; pc <= n_pc; hlt <= n_hlt;
          print_valid <= n_pv; print_value <= n_pv ? 32'(opb) : '0;
          fault_code <= f;
          fbase <= sp + 1'b1; frame_bp <= bp; frame_ret <= nxt[PA-1:0];
          frame_lnk <= lnk; wslot <= '0;
          ex_waddr <= n_waddr; ex_wdata <= n_wdata;
        end
        CMD_WR: wslot <= wslot + 1'b1;
        default: ;
      endcase
    end
  end

  // alu result write is issued in the cycle after exec
  always_ff @(posedge clk) begin
    if (rst) ex_wr <= 1'b0;
    else ex_wr <= (ctl.cmd == CMD_EXEC) && n_wr;
  end

  // status and outputs
  assign stat.clear_last = (32'(clr) == STACK_DEPTH - 1);
  assign stat.links_left = (links != '0);
  assign stat.div_busy   = div_busy || div_go;
  assign stat.need_div   = (op == OP_OPR) && (mop == OPR_DIV || mop == OPR_MOD);
  assign stat.frame_wr   = (op == OP_CAL) && (fault_code == FLT_NONE) && !lev_bad;
  assign stat.halted     = hlt;

  assign next_pc         = 9'(pc);
  assign frame_base      = 8'(bp);
  assign stack_top_index = 8'(sp);
  assign top_value       = 32'(rd_data);
  assign halted          = hlt;
endmodule

### hw/rtl/pl0_control.sv
// pl0_control: sequencer for clearing, link walk, operand reads, divide, commit,
// call frame writes and top-of-stack read; depends on pl0_pkg
module pl0_control (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [3:0]          opcode,
  output logic                busy,
  output logic                done,
  output pl0_pkg::dp_cmd_t    ctl,
  input  pl0_pkg::dp_stat_t   stat
);
  import pl0_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_LINKR = 11'b00000000100,
    S_LINK  = 11'b00000001000,
    S_RDB   = 11'b00000010000,
    S_RDA   = 11'b00000100000,
    S_CAPA  = 11'b00001000000,
    S_DIV   = 11'b00010000000,
    S_EXEC  = 11'b00100000000,
    S_WR    = 11'b01000000000,
    S_TOP   = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic [1:0] step, step_next;
  logic [3:0] op;
  logic       done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; step <= '0; done <= 1'b0;
    end else begin
      state <= state_next; step <= step_next; done <= done_next;
    end
    if (start && !busy) op <= opcode;
  end

  // sequencing: rd b = top, rd a = second or frame/address word
  always_comb begin
    state_next = state; step_next = step; ctl.cmd = CMD_NONE; ctl.sel = 2'd0;
    done_next = 1'b0;
    case (state)
      S_CLEAR: begin
        ctl.cmd = CMD_CLEAR;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ctl.cmd = CMD_LOAD;
          state_next = stat.halted ? S_TOP : S_LINKR;
        end
      end
      S_LINKR: begin
        ctl.sel = 2'd2;
        state_next = stat.links_left ? S_LINK : S_RDB;
      end
      S_LINK: begin
        ctl.cmd = CMD_LINK; state_next = S_LINKR;
      end
      S_RDB: begin
        // top of stack, or return address for RET
        ctl.sel = 2'd0; state_next = S_RDA;
      end
      S_RDA: begin
        // capture b, issue the read of a
        ctl.cmd = CMD_RDA; ctl.sel = 2'd1; state_next = S_CAPA;
      end
      S_CAPA: begin
        ctl.cmd = CMD_OPS;
        state_next = stat.need_div ? S_DIV : S_EXEC;
      end
      S_DIV: begin
        if (step == 2'd0) begin
          ctl.cmd = CMD_DIVGO; step_next = 2'd1;
        end else if (!stat.div_busy) begin
          step_next = '0; state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.cmd = CMD_EXEC; state_next = (op == OP_CAL) ? S_WR : S_TOP;
      end
      S_WR: begin
        if (stat.frame_wr) ctl.cmd = CMD_WR;
        step_next = step + 1'b1;
        if (step == 2'd3) begin step_next = '0; state_next = S_TOP; end
      end
      S_TOP: begin
        ctl.cmd = CMD_TOPRD;
        if (step == 2'd0) step_next = 2'd1;
        else begin step_next = '0; state_next = S_IDLE; done_next = 1'b1; end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_start_leaves: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted without leaving idle");
endmodule

### hw/rtl/pl0_stack_machine_step_unit.sv
// pl0_stack_machine_step_unit: top level of the p-machine step unit
// depends on pl0_pkg, pl0_control, pl0_datapath, pl0_divider
//
// Executes one p-machine instruction per item. After reset the stack memory
// is cleared one word per cycle, with busy high. An item is taken when start
// is high and busy low; its result appears for one cycle with done high.
// busy is already low in that cycle, so the next item can be taken at its
// end. Each static link followed adds a link read and a link step, DIV and
// MOD wait for the bit-serial divider and CAL adds its frame writes; once
// halted, an item goes straight to the top-of-stack read. One read and one
// write per cycle on the stack memory set the step count.
// The receiver cannot stall: done is a one-cycle strobe.
module pl0_stack_machine_step_unit #(
  parameter int STACK_DEPTH = pl0_pkg::STACK_DEPTH_DEF,
  parameter int CODE_DEPTH  = pl0_pkg::CODE_DEPTH_DEF,
  parameter int MAX_LEVELS  = pl0_pkg::MAX_LEVELS_DEF,
  parameter int WORD_BITS   = pl0_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic [3:0]         opcode,
  input  logic [1:0]         lex_level,
  input  logic signed [31:0] operand_m,
  input  logic signed [31:0] read_value,
  output logic [8:0]         next_pc,
  output logic [7:0]         frame_base,
  output logic [7:0]         stack_top_index,
  output logic signed [31:0] top_value,
  output logic               print_valid,
  output logic signed [31:0] print_value,
  output logic               halted,
  output logic [1:0]         fault_code
);
  import pl0_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;

  pl0_control u_ctl (
    .clk(clk), .rst(rst), .start(start), .opcode(opcode), .busy(busy),
    .done(done), .ctl(ctl), .stat(stat)
  );

  pl0_datapath #(
    .STACK_DEPTH(STACK_DEPTH), .CODE_DEPTH(CODE_DEPTH),
    .MAX_LEVELS(MAX_LEVELS), .WORD_BITS(WORD_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .stat(stat),
    .opcode(opcode), .lex_level(lex_level), .operand_m(operand_m),
    .read_value(read_value), .next_pc(next_pc), .frame_base(frame_base),
    .stack_top_index(stack_top_index), .top_value(top_value),
    .print_valid(print_valid), .print_value(print_value), .halted(halted),
    .fault_code(fault_code)
  );
endmodule
